>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_IMPL(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NEXT(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("next-cycle implication failed");

`endif

>>> sv/avrid_pkg.sv
package avrid_pkg;

	localparam int KindW = 6;
	localparam int RegW  = 5;
	localparam int ImmW  = 13;

	typedef logic [KindW-1:0] kind_t;
	typedef logic [RegW-1:0]  reg_idx_t;

	localparam kind_t K_NOP    = 6'd0;
	localparam kind_t K_MOVW   = 6'd1;
	localparam kind_t K_MULS   = 6'd2;
	localparam kind_t K_MULSU  = 6'd3;
	localparam kind_t K_FMUL   = 6'd4;
	localparam kind_t K_FMULS  = 6'd5;
	localparam kind_t K_FMULSU = 6'd6;
	localparam kind_t K_CPC    = 6'd7;
	localparam kind_t K_SBC    = 6'd8;
	localparam kind_t K_ADD    = 6'd9;
	localparam kind_t K_ADC    = 6'd10;
	localparam kind_t K_ADIW   = 6'd11;
	localparam kind_t K_LDI    = 6'd12;
	localparam kind_t K_IN     = 6'd13;
	localparam kind_t K_OUT    = 6'd14;
	localparam kind_t K_PUSH   = 6'd15;
	localparam kind_t K_POP    = 6'd16;
	localparam kind_t K_LD     = 6'd17;
	localparam kind_t K_LDD    = 6'd18;
	localparam kind_t K_ST     = 6'd19;
	localparam kind_t K_STD    = 6'd20;
	localparam kind_t K_RCALL  = 6'd21;
	localparam kind_t K_COM    = 6'd22;
	localparam kind_t K_NEG    = 6'd23;
	localparam kind_t K_SWAP   = 6'd24;
	localparam kind_t K_INC    = 6'd25;
	localparam kind_t K_ASR    = 6'd26;
	localparam kind_t K_LSR    = 6'd27;
	localparam kind_t K_ROR    = 6'd28;
	localparam kind_t K_DEC    = 6'd29;
	localparam kind_t K_SEC    = 6'd30;
	localparam kind_t K_CLC    = 6'd38;
	localparam kind_t K_RET    = 6'd46;
	localparam kind_t K_MOV    = 6'd47;
	localparam kind_t K_LAST   = K_MOV;

	localparam reg_idx_t PTR_Y = 5'd28;
	localparam reg_idx_t PTR_Z = 5'd30;

	typedef struct packed {
		logic signed [ImmW-1:0] imm;
		logic                   u2;
		reg_idx_t               r2;
		logic                   u1;
		reg_idx_t               r1;
		logic                   bad;
		kind_t                  kind;
	} dec_t;

endpackage

>>> sv/avr_instruction_decoder_top.sv
// An accepted input reaches the result on the master side through the input
// register, then decode into the result register.
// Throughput: one item per cycle; the pipeline stalls only on m_axis_tready.
// Reset: arst_n clears both stage valid flags asynchronously; data registers
// are not reset.
`include "assert_macros.svh"

module avr_instruction_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// instr_high [7:0], instr_low [15:8]
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// op_kind [5:0], unimplemented [6], first_reg [11:7], first_used [12],
	// second_reg [17:13], second_used [18], immediate [31:19]
	output logic [31:0] m_axis_tdata
);

	logic [15:0]    instr_s1;
	logic           valid_s1;
	avrid_pkg::dec_t dec_s2;
	logic           valid_s2;
	avrid_pkg::dec_t dec;
	logic           adv2;

	logic [7:0] hi;
	logic [7:0] lo;
	avrid_pkg::reg_idx_t rd;
	avrid_pkg::reg_idx_t rr;
	avrid_pkg::reg_idx_t ptr;
	logic [5:0] q;

	assign adv2          = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv2;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = dec_s2;

	assign hi  = instr_s1[7:0];
	assign lo  = instr_s1[15:8];
	assign rd  = {hi[0], lo[7:4]};
	assign rr  = {hi[1], lo[3:0]};
	assign q   = {hi[5], hi[3:2], lo[2:0]};
	assign ptr = lo[3] ? avrid_pkg::PTR_Y : avrid_pkg::PTR_Z;

	// Unmatched words fall through with only the bad flag set, so every
	// other field of an unimplemented word reads as zero.
	always_comb begin
		dec     = '0;
		dec.bad = 1'b1;
		if (hi == 8'h00) begin
			if (lo == 8'h00) begin
				dec.bad  = 1'b0;
				dec.kind = avrid_pkg::K_NOP;
			end
		end else if (hi == 8'h01) begin
			dec.bad  = 1'b0;
			dec.kind = avrid_pkg::K_MOVW;
			dec.u1   = 1'b1;
			dec.r1   = {lo[7:4], 1'b0};
			dec.u2   = 1'b1;
			dec.r2   = {lo[3:0], 1'b0};
		end else if (hi == 8'h02) begin
			dec.bad  = 1'b0;
			dec.kind = avrid_pkg::K_MULS;
			dec.u1   = 1'b1;
			dec.r1   = {1'b1, lo[7:4]};
			dec.u2   = 1'b1;
			dec.r2   = {1'b1, lo[3:0]};
		end else if (hi == 8'h03) begin
			dec.bad = 1'b0;
			case ({lo[7], lo[3]})
				2'b00:   dec.kind = avrid_pkg::K_MULSU;
				2'b01:   dec.kind = avrid_pkg::K_FMUL;
				2'b10:   dec.kind = avrid_pkg::K_FMULS;
				default: dec.kind = avrid_pkg::K_FMULSU;
			endcase
			dec.u1 = 1'b1;
			dec.r1 = {2'b10, lo[6:4]};
			dec.u2 = 1'b1;
			dec.r2 = {2'b10, lo[2:0]};
		end else if (hi[7:2] inside {6'b000001, 6'b000010, 6'b000011, 6'b000111,
				6'b001011}) begin
			dec.bad = 1'b0;
			case (hi[7:2])
				6'b000001: dec.kind = avrid_pkg::K_CPC;
				6'b000010: dec.kind = avrid_pkg::K_SBC;
				6'b000011: dec.kind = avrid_pkg::K_ADD;
				6'b000111: dec.kind = avrid_pkg::K_ADC;
				default:   dec.kind = avrid_pkg::K_MOV;
			endcase
			dec.u1 = 1'b1;
			dec.r1 = rd;
			dec.u2 = 1'b1;
			dec.r2 = rr;
		end else if (hi[7:4] == 4'hE) begin
			dec.bad  = 1'b0;
			dec.kind = avrid_pkg::K_LDI;
			dec.u1   = 1'b1;
			dec.r1   = {1'b1, lo[7:4]};
			dec.imm  = {5'b0, hi[3:0], lo[3:0]};
		end else if (hi == 8'h96) begin
			dec.bad  = 1'b0;
			dec.kind = avrid_pkg::K_ADIW;
			dec.u1   = 1'b1;
			dec.r1   = {2'b11, lo[5:4], 1'b0};
			dec.imm  = {7'b0, lo[7:6], lo[3:0]};
		end else if (hi[7:4] == 4'hB) begin
			dec.bad = 1'b0;
			dec.imm = {7'b0, hi[2:1], lo[3:0]};
			if (!hi[3]) begin
				dec.kind = avrid_pkg::K_IN;
				dec.u1   = 1'b1;
				dec.r1   = rd;
			end else begin
				dec.kind = avrid_pkg::K_OUT;
				dec.u2   = 1'b1;
				dec.r2   = rd;
			end
		end else if (hi[7:1] inside {7'b1001001, 7'b1001000}) begin
			if (lo[3:0] == 4'hF) begin
				dec.bad  = 1'b0;
				dec.kind = hi[1] ? avrid_pkg::K_PUSH : avrid_pkg::K_POP;
				dec.u1   = 1'b1;
				dec.r1   = rd;
			end
		end else if (hi[7] && !hi[6] && !hi[4]) begin
			// Displacement form through Y or Z; a zero displacement is plain LD/ST.
			dec.bad = 1'b0;
			dec.u1  = 1'b1;
			dec.u2  = 1'b1;
			dec.imm = {7'b0, q};
			if (!hi[1]) begin
				dec.kind = (q != 6'd0) ? avrid_pkg::K_LDD : avrid_pkg::K_LD;
				dec.r1   = rd;
				dec.r2   = ptr;
			end else begin
				dec.kind = (q != 6'd0) ? avrid_pkg::K_STD : avrid_pkg::K_ST;
				dec.r1   = ptr;
				dec.r2   = rd;
			end
		end else if (hi[7:4] == 4'hD) begin
			dec.bad  = 1'b0;
			dec.kind = avrid_pkg::K_RCALL;
			dec.imm  = {hi[3:0], lo, 1'b0};
		end else if (hi[7:1] == 7'b1001010) begin
			case (lo[3:0])
				4'h0, 4'h1, 4'h2, 4'h3, 4'h5, 4'h6, 4'h7, 4'hA: begin
					dec.bad = 1'b0;
					dec.u1  = 1'b1;
					dec.r1  = rd;
					case (lo[3:0])
						4'h0:    dec.kind = avrid_pkg::K_COM;
						4'h1:    dec.kind = avrid_pkg::K_NEG;
						4'h2:    dec.kind = avrid_pkg::K_SWAP;
						4'h3:    dec.kind = avrid_pkg::K_INC;
						4'h5:    dec.kind = avrid_pkg::K_ASR;
						4'h6:    dec.kind = avrid_pkg::K_LSR;
						4'h7:    dec.kind = avrid_pkg::K_ROR;
						default: dec.kind = avrid_pkg::K_DEC;
					endcase
				end
				4'h8: begin
					// The set ops and then the clear ops follow SEC in one run.
					if (hi == 8'h94) begin
						dec.bad  = 1'b0;
						dec.kind = avrid_pkg::K_SEC + {2'b00, lo[7:4]};
					end else if (lo == 8'h08) begin
						dec.bad  = 1'b0;
						dec.kind = avrid_pkg::K_RET;
					end
				end
				default: dec.bad = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					dec_s2 <= dec;
				end
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
				if (s_axis_tvalid) begin
					instr_s1 <= s_axis_tdata;
				end
			end
		end
	end

	`ASSERT_IMPL(a_unimpl_clear, m_axis_tvalid && dec_s2.bad, dec_s2.kind == '0 && !dec_s2.u1 && !dec_s2.u2 && dec_s2.imm == '0)
	`ASSERT_IMPL(a_unused_regs_zero, m_axis_tvalid, (dec_s2.u1 || dec_s2.r1 == '0) && (dec_s2.u2 || dec_s2.r2 == '0))
	`ASSERT_IMPL(a_kind_range, m_axis_tvalid, dec_s2.kind <= avrid_pkg::K_LAST)
	`ASSERT_NEXT(a_s1_held, valid_s1 && !adv2, valid_s1 && $stable(instr_s1))

endmodule
